FILE: src/pkbf_pkg.sv
// shared types and constants for the pixel kalman bilateral fusion block
`default_nettype none
package pkbf_pkg;
    localparam int IDX_W = 19;
    localparam int PIXELS_DEFAULT = 524288;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_R = 1'b1;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PROC = 1'b1;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] pixel_index;
        logic [7:0]       pixel_value;
        logic [7:0]       box_mean;
        logic [15:0]      bilateral_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [7:0]       denoised;
    } out_item_t;
endpackage
`default_nettype wire

FILE: src/pkbf_stream_if.sv
// valid/ready stream interface carrying one request payload
`default_nettype none
interface pkbf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/pixel_kalman_bilateral_fusion.sv
// per pixel kalman denoiser fused with bilateral value, pipelined top level
// pipeline from request accept to result valid: read, square, predict,
//   17 stage restoring divider, two blend stages, seven delay stages, output register
// one request per cycle unless stalled; a request whose pixel is in flight waits for its write back
// stalls freeze the whole pipeline; state memories are read and written through ports
// reset clears valid bits and config to 1.0; state memories are undefined until loaded
`default_nettype none
module pixel_kalman_bilateral_fusion
    import pkbf_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEFAULT
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [pkbf_pkg::CFG_IDX_W:0] cfg_index,
    input  wire logic [pkbf_pkg::CFG_W-1:0] cfg_data,
    pkbf_stream_if.sink   in_req,
    pkbf_stream_if.source out_res
);
    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int NS = 29;

    logic [31:0] q_reg, r_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= ONE_Q16;
            r_reg <= ONE_Q16;
        end
        else if (cfg_we && cfg_index[CFG_IDX_W] == 1'b0)
        begin
            if (cfg_index[CFG_IDX_W-1:0] == CFG_Q)
                q_reg <= cfg_data;
            else
                r_reg <= cfg_data;
        end
    end

    logic adv;
    logic [NS-1:0] v_reg;
    logic out_v_reg;
    out_item_t out_reg;
    assign adv = !out_v_reg || out_res.ready;

    // per stage payload
    in_item_t   it   [NS];
    logic        inr  [NS];
    logic [15:0] x    [NS];
    logic [31:0] p    [NS];
    logic [7:0]  pv   [NS];
    logic [32:0] rem  [NS];
    logic [16:0] quo  [NS];
    logic [32:0] den  [NS];
    logic [47:0] num  [NS];
    logic [15:0] m    [NS];
    logic [15:0] xn   [NS];
    logic [31:0] pn   [NS];

    logic [15:0] x_mem [PIXELS];
    logic [31:0] p_mem [PIXELS];
    logic [7:0]  m_mem [PIXELS];

    in_item_t it_in;
    logic in_range;
    assign it_in = in_req.payload;
    assign in_range = {6'd0, it_in.pixel_index} < 25'(PIXELS);

    // hold a request while the same pixel is still in flight
    logic [NS-1:0] hit;
    logic hazard;
    always_comb
    begin
        for (int s = 0; s < NS; s++)
            hit[s] = v_reg[s] && (it[s].pixel_index == it_in.pixel_index);
    end
    assign hazard = |hit;
    assign in_req.ready = adv && !hazard;

    // write back at last stage
    logic wb_en;
    logic [AW-1:0] wb_a;
    assign wb_en = adv && v_reg[NS-1] && inr[NS-1];
    assign wb_a  = it[NS-1].pixel_index[AW-1:0];

    // state read at accept, written back from the last stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x[0] <= x_mem[it_in.pixel_index[AW-1:0]];
            p[0] <= p_mem[it_in.pixel_index[AW-1:0]];
            pv[0] <= m_mem[it_in.pixel_index[AW-1:0]];
            it[0] <= it_in;
            inr[0] <= in_range;
        end
        if (wb_en)
        begin
            x_mem[wb_a] <= xn[NS-1];
            p_mem[wb_a] <= pn[NS-1];
            m_mem[wb_a] <= (it[NS-1].action == ACT_LOAD) ? 8'd0 : it[NS-1].box_mean;
        end
    end

    // stage 1: square of the mean change
    logic [7:0] dd;
    logic [15:0] d2_reg;
    assign dd = (pv[0] > it[0].box_mean) ? pv[0] - it[0].box_mean : it[0].box_mean - pv[0];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg <= dd * dd;
            it[1] <= it[0]; inr[1] <= inr[0]; x[1] <= x[0]; p[1] <= p[0];
        end
    end

    // stage 2: predicted variance, saturated
    // quotient fits 17 bits, so the top 31 dividend bits seed the remainder
    logic [47:0] qd;
    logic [48:0] pp_sum;
    logic [31:0] pp;
    assign qd = q_reg * d2_reg;
    assign pp_sum = 49'(p[1]) + 49'(qd);
    assign pp = (pp_sum[48:32] != 17'd0) ? 32'hFFFF_FFFF : pp_sum[31:0];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it[2] <= it[1]; inr[2] <= inr[1]; x[2] <= x[1];
            p[2] <= pp;
            den[2] <= 33'(pp) + 33'(r_reg);
            num[2] <= {pp, 16'd0};
            rem[2] <= {2'b00, pp[31:1]};
            quo[2] <= 17'd0;
        end
    end

    // stages 3..19: restoring division, one quotient bit per stage
    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            logic [33:0] tr;
            assign tr = {rem[g+2], num[g+2][16-g]};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    it[g+3] <= it[g+2]; inr[g+3] <= inr[g+2]; x[g+3] <= x[g+2];
                    p[g+3] <= p[g+2]; den[g+3] <= den[g+2]; num[g+3] <= num[g+2];
                    if (tr >= {1'b0, den[g+2]})
                    begin
                        rem[g+3] <= 33'(tr - {1'b0, den[g+2]});
                        quo[g+3] <= {quo[g+2][15:0], 1'b1};
                    end
                    else
                    begin
                        rem[g+3] <= tr[32:0];
                        quo[g+3] <= {quo[g+2][15:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // gain is 1.0 when the divisor is zero
    localparam int KS = 19;
    logic [16:0] k;
    assign k = (den[KS] == 33'd0) ? 17'h10000 : quo[KS];

    // stage 20: first blend and variance update
    logic [16:0] kc;
    assign kc = 17'h10000 - k;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it[20] <= it[KS]; inr[20] <= inr[KS];
            m[20] <= 16'((34'(x[KS]) * kc + 34'({it[KS].pixel_value, 8'd0}) * k
                         + 34'd32768) >> 16);
            pn[20] <= 32'((49'(p[KS]) * kc + 49'd32768) >> 16);
            quo[20] <= k;
        end
    end

    // stage 21: second blend
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it[21] <= it[20]; inr[21] <= inr[20]; pn[21] <= pn[20];
            xn[21] <= 16'((34'(m[20]) * (17'h10000 - quo[20])
                          + 34'(it[20].bilateral_value) * quo[20] + 34'd32768) >> 16);
        end
    end

    // stages 22..28: delay line, load items substitute their state here
    generate
        for (g = 22; g < NS; g++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    it[g] <= it[g-1]; inr[g] <= inr[g-1];
                    if (g == 22 && it[g-1].action == ACT_LOAD)
                    begin
                        xn[g] <= {it[g-1].pixel_value, 8'd0};
                        pn[g] <= ONE_Q16;
                    end
                    else
                    begin
                        xn[g] <= xn[g-1];
                        pn[g] <= pn[g-1];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_req.valid && !hazard};
            out_v_reg <= v_reg[NS-1];
        end
    end

    logic [8:0] rnd;
    assign rnd = 9'((17'(xn[NS-1]) + 17'd128) >> 8);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.out_index <= it[NS-1].pixel_index;
            out_reg.denoised <= !inr[NS-1] ? 8'd0 : (rnd[8] ? 8'hFF : rnd[7:0]);
        end
    end

    assign out_res.valid = out_v_reg;
    assign out_res.payload = out_reg;

    unused_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_res.ready) |=> out_v_reg) else $error("result dropped");
    stall_a: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg)) else $error("pipeline moved during stall");
    k_a: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[KS] && inr[KS] && it[KS].action == ACT_PROC) |-> k <= 17'h10000)
        else $error("gain above one");
endmodule
`default_nettype wire
